/* rtl/tlik_pkg.sv */
// shared types, constants and angle step table for the two-link arm solver
package tlik_pkg;

  localparam int COORD_BITS_DEF    = 8;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TABLE_BITS        = 24;
  localparam int LINK_BITS         = 7;
  localparam int INDEX_BITS        = 2;
  localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;
  localparam logic [LINK_BITS-1:0] LINK_RESET = 7'd5;

  localparam logic [INDEX_BITS-1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_SECOND_LINK = 2'd1;

  localparam logic [63:0] STEP_Q24 [10] = '{
    64'd754974720, 64'd445687602, 64'd235489088, 64'd119537938, 64'd60000934,
    64'd30029717, 64'd15018523, 64'd7509720, 64'd3754917, 64'd1877466
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP1, ST_PREP2, ST_PREP3, ST_PREP4, ST_JOB_START, ST_SQRT,
    ST_VEC_START, ST_NORM, ST_CORDIC, ST_POST, ST_BASE, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    JOB_ELBOW, JOB_REACH, JOB_ATAN
  } job_t;

  // atan(2^-i) in degrees, rounded half up to fb fractional bits
  function automatic logic [63:0] step_angle(input int unsigned i, input int unsigned fb);
    logic [63:0] v;
    int unsigned sh;
    if (i < 10) begin
      v = STEP_Q24[i];
    end else if (i < 40) begin
      v = (DEG_PER_RAD_Q24 + (64'd1 << (i - 1))) >> i;
    end else begin
      v = 64'd0;
    end
    sh = TABLE_BITS - fb;
    if (sh > 0) begin
      v = (v + (64'd1 << (sh - 1))) >> sh;
    end
    return v;
  endfunction

endpackage

/* rtl/two_link_arm_inverse_kinematics.sv */
// Two-link planar arm inverse kinematics: base and elbow angles in whole degrees
// from a target point. One item at a time: in_ready is high only while the solver is
// idle. An item runs three angle jobs in turn on one shared unit; each acos job runs
// a 32-step bit-pair square root, then a one bit per cycle normalizing shift and
// FRACTION_BITS+2 vectoring steps; the atan job skips the square root. A point on the
// y axis skips the atan job, and a point on the edge of reach skips the square root
// and vectoring of an acos job, so these finish sooner. The origin and points out of
// reach go straight from the preparation states to the finish. A finished result
// sits in the output register, so the next item is taken while it waits.
// Configuration writes are always taken.
module two_link_arm_inverse_kinematics #(
  parameter int FRACTION_BITS = tlik_pkg::FRACTION_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [tlik_pkg::INDEX_BITS-1:0]             cfg_index,
  input  logic [tlik_pkg::LINK_BITS-1:0]              cfg_data,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [tlik_pkg::COORD_BITS_DEF-1:0]  target_x,
  input  logic signed [tlik_pkg::COORD_BITS_DEF-1:0]  target_y,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [9:0]                           base_angle,
  output logic [7:0]                                  elbow_angle,
  output logic                                        out_of_reach
);

  localparam int COORD_BITS = tlik_pkg::COORD_BITS_DEF;
  localparam int FB = FRACTION_BITS;
  localparam int SW = 2 * COORD_BITS;
  localparam int DW = SW + 2;
  localparam int CW = FB + 6;
  localparam int AW = FB + 11;
  localparam int NSTEP = FB + 2;
  localparam int IW = $clog2(NSTEP + 1);
  localparam logic [63:0] LO = 64'd1 << (FB + 2);
  localparam logic signed [AW-1:0] RIGHT = AW'(90) <<< FB;
  localparam logic signed [AW-1:0] HALF = AW'(180) <<< FB;

  tlik_pkg::state_t state, state_next;
  tlik_pkg::job_t jsel;

  logic [tlik_pkg::LINK_BITS-1:0] l1, l2;
  logic signed [9:0] last_base;
  logic signed [COORD_BITS-1:0] xr, yr;
  logic [SW-1:0] xx, yy;
  logic [13:0] l1sq, l2sq, p;
  logic [16:0] s17;
  logic [14:0] m;
  logic signed [15:0] dreg;
  logic signed [17:0] n1;
  logic signed [31:0] dd;
  logic [29:0] mm;
  logic signed [35:0] n1sq;
  logic [30:0] q;
  logic [63:0] h1r;
  logic signed [17:0] jc;
  logic [63:0] jh, va, vb, sq_v, sq_res, sq_bit;
  logic signed [CW-1:0] cx, cy;
  logic signed [AW-1:0] cz, zang, a1, at;
  logic [IW-1:0] ci;
  logic [7:0] elbow_deg;
  logic signed [9:0] res_base;
  logic [7:0] res_elbow;
  logic res_flag, res_upd;

  // combinational helpers
  logic [SW-1:0] s_full;
  logic signed [DW-1:0] d_full, m_s;
  logic far, origin, slot_free;
  logic signed [37:0] h1s;
  logic [17:0] mag;
  logic [4:0] k;
  logic [63:0] sq_sum, res_nx, top;
  logic sq_take;
  logic signed [CW-1:0] dx, dy, cx_nx, cy_nx;
  logic signed [AW-1:0] t, cz_nx, cz_clamp, post_r;
  logic x_neg;

  function automatic logic signed [AW-1:0] whole(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] n;
    n = -v;
    return (v >= 0) ? (v >>> FB) : -(n >>> FB);
  endfunction

  assign x_neg = xr[COORD_BITS-1];

  always_comb begin
    s_full = xx + yy;
    d_full = $signed(DW'(s_full)) - $signed(DW'(l1sq)) - $signed(DW'(l2sq));
    m_s = $signed(DW'({p, 1'b0}));
    far = (l1 == '0) || (l2 == '0) || (d_full > m_s) || (d_full < -m_s);
    origin = (xr == '0) && (yr == '0);
    h1s = $signed(38'({q, 2'b00})) - 38'(n1sq);
    mag = jc[17] ? 18'(-jc) : 18'(jc);
    k = '0;
    for (int j = 0; j < 16; j++) begin
      if (((jh >> (60 - 2 * j)) == 64'd0) && ((64'(mag) >> (61 - j)) == 64'd0)) begin
        k = k + 5'd1;
      end
    end
    sq_sum = sq_res + sq_bit;
    sq_take = (sq_v >= sq_sum);
    res_nx = sq_take ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
    top = (va > vb) ? va : vb;
    dx = cy >>> ci;
    dy = cx >>> ci;
    t = AW'(tlik_pkg::step_angle(32'(ci), FB));
    if (cy >= 0) begin
      cx_nx = cx + dx;
      cy_nx = cy - dy;
      cz_nx = cz + t;
    end else begin
      cx_nx = cx - dx;
      cy_nx = cy + dy;
      cz_nx = cz - t;
    end
    if (cz_nx < 0) begin
      cz_clamp = '0;
    end else if (cz_nx > RIGHT) begin
      cz_clamp = RIGHT;
    end else begin
      cz_clamp = cz_nx;
    end
    if (jsel == tlik_pkg::JOB_ATAN) begin
      post_r = (x_neg != yr[COORD_BITS-1]) ? -zang : zang;
    end else begin
      post_r = (jc > 0) ? zang : HALF - zang;
    end
  end

  // control outputs
  always_comb begin
    in_ready = (state == tlik_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    slot_free = !out_valid || out_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tlik_pkg::ST_IDLE: begin
        if (in_valid) state_next = tlik_pkg::ST_PREP1;
      end
      tlik_pkg::ST_PREP1: state_next = tlik_pkg::ST_PREP2;
      tlik_pkg::ST_PREP2: begin
        state_next = (origin || far) ? tlik_pkg::ST_FINISH : tlik_pkg::ST_PREP3;
      end
      tlik_pkg::ST_PREP3: state_next = tlik_pkg::ST_PREP4;
      tlik_pkg::ST_PREP4: state_next = tlik_pkg::ST_JOB_START;
      tlik_pkg::ST_JOB_START: begin
        state_next = (jh == '0 || jc == '0) ? tlik_pkg::ST_POST : tlik_pkg::ST_SQRT;
      end
      tlik_pkg::ST_SQRT: begin
        if (sq_bit[0]) state_next = tlik_pkg::ST_VEC_START;
      end
      tlik_pkg::ST_VEC_START: begin
        state_next = (vb == '0 || va == '0) ? tlik_pkg::ST_POST : tlik_pkg::ST_NORM;
      end
      tlik_pkg::ST_NORM: begin
        if (top < (LO << 1) && top >= LO) state_next = tlik_pkg::ST_CORDIC;
      end
      tlik_pkg::ST_CORDIC: begin
        if (ci == IW'(NSTEP - 1)) state_next = tlik_pkg::ST_POST;
      end
      tlik_pkg::ST_POST: begin
        case (jsel)
          tlik_pkg::JOB_ELBOW: state_next = tlik_pkg::ST_JOB_START;
          tlik_pkg::JOB_REACH: begin
            state_next = (xr == '0) ? tlik_pkg::ST_BASE : tlik_pkg::ST_VEC_START;
          end
          default: state_next = tlik_pkg::ST_BASE;
        endcase
      end
      tlik_pkg::ST_BASE: state_next = tlik_pkg::ST_FINISH;
      tlik_pkg::ST_FINISH: begin
        if (slot_free) state_next = tlik_pkg::ST_IDLE;
      end
      default: state_next = tlik_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlik_pkg::ST_IDLE;
      l1 <= tlik_pkg::LINK_RESET;
      l2 <= tlik_pkg::LINK_RESET;
      last_base <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == tlik_pkg::REG_FIRST_LINK) l1 <= cfg_data;
        else if (cfg_index == tlik_pkg::REG_SECOND_LINK) l2 <= cfg_data;
      end
      if (out_ready) out_valid <= 1'b0;
      if (state == tlik_pkg::ST_FINISH && slot_free) begin
        out_valid <= 1'b1;
        if (res_upd) last_base <= res_base;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      tlik_pkg::ST_IDLE: begin
        xr <= target_x;
        yr <= target_y;
      end
      tlik_pkg::ST_PREP1: begin
        xx <= SW'(xr * xr);
        yy <= SW'(yr * yr);
        l1sq <= l1 * l1;
        l2sq <= l2 * l2;
        p <= l1 * l2;
      end
      tlik_pkg::ST_PREP2: begin
        s17 <= 17'(s_full);
        m <= {p, 1'b0};
        dreg <= 16'(d_full);
        n1 <= 18'(d_full) + $signed(18'({l1sq, 1'b0}));
        if (origin) begin
          res_base <= last_base;
          res_elbow <= 8'd180;
          res_flag <= 1'b0;
          res_upd <= 1'b0;
        end else begin
          res_base <= '0;
          res_elbow <= '0;
          res_flag <= 1'b1;
          res_upd <= 1'b1;
        end
      end
      tlik_pkg::ST_PREP3: begin
        dd <= dreg * dreg;
        mm <= m * m;
        n1sq <= n1 * n1;
        q <= l1sq * s17;
      end
      tlik_pkg::ST_PREP4: begin
        h1r <= (h1s < 0) ? 64'd0 : 64'(h1s);
        jh <= 64'(mm) - 64'(unsigned'(dd));
        jc <= 18'(dreg);
        jsel <= tlik_pkg::JOB_ELBOW;
      end
      tlik_pkg::ST_JOB_START: begin
        if (jh == '0) begin
          zang <= (jc == '0) ? HALF : '0;
        end else if (jc == '0) begin
          zang <= RIGHT;
        end
        sq_v <= jh << {k, 1'b0};
        va <= 64'(mag) << k;
        sq_res <= '0;
        sq_bit <= 64'd1 << 62;
      end
      tlik_pkg::ST_SQRT: begin
        if (sq_take) sq_v <= sq_v - sq_sum;
        sq_res <= res_nx;
        sq_bit <= sq_bit >> 2;
        vb <= res_nx;
      end
      tlik_pkg::ST_VEC_START: begin
        if (vb == '0) zang <= '0;
        else if (va == '0) zang <= RIGHT;
      end
      tlik_pkg::ST_NORM: begin
        if (top >= (LO << 1)) begin
          va <= va >> 1;
          vb <= vb >> 1;
        end else if (top < LO) begin
          va <= va << 1;
          vb <= vb << 1;
        end else begin
          cx <= $signed(CW'(va));
          cy <= $signed(CW'(vb));
          cz <= '0;
          ci <= '0;
        end
      end
      tlik_pkg::ST_CORDIC: begin
        cx <= cx_nx;
        cy <= cy_nx;
        cz <= cz_nx;
        ci <= ci + 1'b1;
        zang <= cz_clamp;
      end
      tlik_pkg::ST_POST: begin
        case (jsel)
          tlik_pkg::JOB_ELBOW: begin
            elbow_deg <= 8'(whole(post_r));
            jc <= n1;
            jh <= h1r;
            jsel <= tlik_pkg::JOB_REACH;
          end
          tlik_pkg::JOB_REACH: begin
            a1 <= post_r;
            if (yr > 0) at <= RIGHT;
            else at <= -RIGHT;
            va <= x_neg ? 64'(-(COORD_BITS + 1)'(xr)) : 64'(xr);
            vb <= yr[COORD_BITS-1] ? 64'(-(COORD_BITS + 1)'(yr)) : 64'(yr);
            jsel <= tlik_pkg::JOB_ATAN;
          end
          default: at <= post_r;
        endcase
      end
      tlik_pkg::ST_BASE: begin
        res_base <= 10'(whole(at - a1)) + (x_neg ? 10'sd180 : 10'sd0);
        res_elbow <= elbow_deg;
        res_flag <= 1'b0;
        res_upd <= 1'b1;
      end
      tlik_pkg::ST_FINISH: begin
        if (slot_free) begin
          base_angle <= res_base;
          elbow_angle <= res_elbow;
          out_of_reach <= res_flag;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/tlik_checker.sv */
// port-level checks for the two-link arm solver, bound to the top level
module tlik_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic signed [9:0] base_angle,
  input logic [7:0]       elbow_angle,
  input logic             out_of_reach
);

  // a waiting result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(base_angle) && $stable(elbow_angle))
    else $error("result changed while waiting");

  // the solver is busy right after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // unreachable points give zero angles
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_reach |-> base_angle == 10'sd0 && elbow_angle == 8'd0)
    else $error("nonzero angles on unreachable point");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> elbow_angle <= 8'd180)
    else $error("elbow angle above half turn");

endmodule

bind two_link_arm_inverse_kinematics tlik_checker u_tlik_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .base_angle(base_angle),
  .elbow_angle(elbow_angle), .out_of_reach(out_of_reach)
);
